FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FET_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property where a condition in one cycle implies another in the next.
`define FET_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/fet_pkg.sv
// Types and constants of the free extent table allocator.
// Used by the front, back, response queue and top level; depends on nothing.
package fet_pkg;

  localparam int FIELD_W    = 16;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RSP_DEPTH  = 4;
  localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
  localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

  // Request codes as they arrive on the input.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_LIST  = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_OPEN,
    SH_CLOSE
  } shift_e;

  typedef enum logic [3:0] {
    BS_INIT,
    BS_IDLE,
    BS_SCAN,
    BS_DECIDE,
    BS_WRA,
    BS_SHIFT,
    BS_WRB,
    BS_RESP,
    BS_LIST
  } back_state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] start_addr;
    logic [FIELD_W-1:0] range_length;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] extent_start;
    logic [FIELD_W-1:0] extent_length;
    logic               last;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_e                op;
    logic               zero_len;
    logic [FIELD_W-1:0] start_addr;
    logic [FIELD_W-1:0] range_length;
  } cmd_t;

endpackage

FILE: hw/rtl/fet_front.sv
// Front end: accepts requests, decodes their kind and queues them for the back.
// Depends on fet_pkg.
module fet_front
  import fet_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output cmd_t cmd_o
);

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t                  cls;
  logic                  do_push, do_pop;

  // Classify the incoming request.
  always_comb begin
    cls.start_addr   = req_i.start_addr;
    cls.range_length = req_i.range_length;
    cls.zero_len     = (req_i.range_length == '0);
    case (req_i.req_type)
      OP_ALLOC: cls.op = OP_ALLOC;
      OP_FREE:  cls.op = OP_FREE;
      OP_LIST:  cls.op = OP_LIST;
      default:  cls.op = OP_BAD;
    endcase
  end

  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: hw/rtl/fet_rsp_fifo.sv
// Result queue between the back end and the result ports.
// Depends on fet_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fet_rsp_fifo
  import fet_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsp_t                 data_i,
  output logic [RSP_CNT_W-1:0] used_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output rsp_t                 data_o
);

  rsp_t                 mem [RSP_DEPTH];
  logic [RSP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RSP_CNT_W-1:0] used_q, used_d;
  logic                 do_push, do_pop;

  assign do_push = push_i && (used_q != RSP_CNT_W'(RSP_DEPTH));
  assign do_pop  = pop_i && (used_q != '0);
  assign used_o  = used_q;
  assign empty_o = (used_q == '0);
  assign data_o  = mem[rd_ptr_q];

  // Fill count.
  always_comb begin
    used_d = used_q;
    if (do_push && !do_pop) begin
      used_d = used_q + 1'b1;
    end else if (!do_push && do_pop) begin
      used_d = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      used_q <= used_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  `FET_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= RSP_CNT_W'(RSP_DEPTH))
  `FET_ASSERT_NEXT(a_pop_only, clk_i, rst_ni, do_pop && !do_push, used_q == $past(used_q) - 1'b1)
  `FET_ASSERT_NEXT(a_push_only, clk_i, rst_ni, do_push && !do_pop, used_q == $past(used_q) + 1'b1)

endmodule

FILE: hw/rtl/fet_back.sv
// Back end: holds the extent table, searches it and edits it one entry a cycle.
// Depends on fet_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fet_back
  import fet_pkg::*;
#(
  parameter int MAX_EXTENTS = 32,
  parameter int ADDR_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_i,
  input  logic [FIELD_W-1:0]   cfg_data_i,
  output logic                 idle_o,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 rsp_push_o,
  output rsp_t                 rsp_o,
  input  logic [RSP_CNT_W-1:0] rsp_used_i
);

  localparam int A  = ADDR_BITS;
  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [A+FIELD_W-1:0] SPACE_RST_EXT = {{A{1'b0}}, 16'hFFFF};

  // Table memory, one write and one registered read per cycle.
  logic [A-1:0] mem_start [MAX_EXTENTS];
  logic [A-1:0] mem_len   [MAX_EXTENTS];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [A-1:0]  wstart, wlen;
  logic [A-1:0]  rd_start_q, rd_len_q;
  logic          rd_ok_q, rd_ok_d;
  logic [AW-1:0] rd_idx_q;

  back_state_e   state_q, state_d;
  logic [A-1:0]  space_q, space_d;
  logic [CW-1:0] count_q, count_d;
  op_e           op_q, op_d;
  logic [A-1:0]  s_q, s_d, len_q, len_d;
  logic [A:0]    e_q, e_d;
  logic          prev_vld_q, prev_vld_d;
  logic [AW-1:0] prev_idx_q, prev_idx_d;
  logic [A-1:0]  prev_start_q, prev_start_d;
  logic [A:0]    prev_end_q, prev_end_d;
  logic [A-1:0]  nxt_start_q, nxt_start_d, nxt_len_q, nxt_len_d;
  logic [CW-1:0] p_q, p_d;
  status_e       status_q, status_d;
  logic          wa_en_q, wa_en_d, wb_en_q, wb_en_d;
  logic [AW-1:0] wa_addr_q, wa_addr_d, wb_addr_q, wb_addr_d;
  logic [A-1:0]  wa_start_q, wa_start_d, wa_len_q, wa_len_d;
  logic [A-1:0]  wb_start_q, wb_start_d, wb_len_q, wb_len_d;
  shift_e        sh_kind_q, sh_kind_d;
  logic [AW-1:0] sh_q, sh_d;
  logic [CW-1:0] rem_q, rem_d;

  // Truncated and extended views of the fields.
  logic [A+FIELD_W-1:0]     cmd_s_ext, cmd_len_ext, cfg_ext;
  logic [A+FIELD_W-1:0]     out_s_ext, out_len_ext;
  logic [A:0]               cmd_e;
  logic [A:0]               rd_end;
  logic [A:0]               s_x, plen, upper;
  logic [A:0]               merged;
  logic                     room, room_list;
  logic [RSP_CNT_W:0]       used_sum;
  logic                     in_ext, join_prev, join_next, has_next, full_tab;

  assign cmd_s_ext   = {{A{1'b0}}, cmd_i.start_addr};
  assign cmd_len_ext = {{A{1'b0}}, cmd_i.range_length};
  assign cfg_ext     = {{A{1'b0}}, cfg_data_i};
  assign out_s_ext   = {{FIELD_W{1'b0}}, rd_start_q};
  assign out_len_ext = {{FIELD_W{1'b0}}, rd_len_q};
  assign cmd_e       = {1'b0, cmd_s_ext[A-1:0]} + {1'b0, cmd_len_ext[A-1:0]};
  assign rd_end      = {1'b0, rd_start_q} + {1'b0, rd_len_q};
  assign s_x         = {1'b0, s_q};
  assign plen        = prev_end_q - {1'b0, prev_start_q};
  assign merged      = plen + {1'b0, len_q} + {1'b0, nxt_len_q};
  assign has_next    = (p_q < count_q);
  assign upper       = has_next ? {1'b0, nxt_start_q} : {1'b0, space_q};
  assign in_ext      = prev_vld_q && (s_x < prev_end_q);
  assign join_prev   = prev_vld_q && (prev_end_q == s_x);
  assign join_next   = has_next && ({1'b0, nxt_start_q} == e_q);
  assign full_tab    = (count_q >= CW'(MAX_EXTENTS));
  assign room        = (rsp_used_i < RSP_CNT_W'(RSP_DEPTH));
  assign used_sum    = (RSP_CNT_W + 1)'(rsp_used_i) + (RSP_CNT_W + 1)'(rd_ok_q);
  assign room_list   = (used_sum < (RSP_CNT_W + 1)'(RSP_DEPTH));
  assign idle_o      = (state_q == BS_IDLE);

  // Sequencer: next state, table port control and result push.
  always_comb begin
    state_d      = state_q;
    space_d      = space_q;
    count_d      = count_q;
    op_d         = op_q;
    s_d          = s_q;
    len_d        = len_q;
    e_d          = e_q;
    prev_vld_d   = prev_vld_q;
    prev_idx_d   = prev_idx_q;
    prev_start_d = prev_start_q;
    prev_end_d   = prev_end_q;
    nxt_start_d  = nxt_start_q;
    nxt_len_d    = nxt_len_q;
    p_d          = p_q;
    status_d     = status_q;
    wa_en_d      = wa_en_q;
    wa_addr_d    = wa_addr_q;
    wa_start_d   = wa_start_q;
    wa_len_d     = wa_len_q;
    wb_en_d      = wb_en_q;
    wb_addr_d    = wb_addr_q;
    wb_start_d   = wb_start_q;
    wb_len_d     = wb_len_q;
    sh_kind_d    = sh_kind_q;
    sh_d         = sh_q;
    rem_d        = rem_q;
    rd_ok_d      = 1'b0;
    raddr        = sh_q;
    we           = 1'b0;
    waddr        = '0;
    wstart       = '0;
    wlen         = '0;
    cmd_pop_o    = 1'b0;
    rsp_push_o   = 1'b0;
    rsp_o        = '0;

    case (state_q)
      // Load the table with one extent over the whole space.
      BS_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wstart  = '0;
        wlen    = space_q;
        count_d = (space_q != '0) ? CW'(1) : '0;
        state_d = BS_IDLE;
      end

      // Take a configuration write or the next queued request.
      BS_IDLE: begin
        if (cfg_wr_i) begin
          space_d = cfg_ext[A-1:0];
          state_d = BS_INIT;
        end else if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          op_d       = cmd_i.op;
          s_d        = cmd_s_ext[A-1:0];
          len_d      = cmd_len_ext[A-1:0];
          e_d        = cmd_e;
          sh_d       = '0;
          rem_d      = count_q;
          prev_vld_d = 1'b0;
          p_d        = count_q;
          if (cmd_i.op == OP_LIST) begin
            state_d = BS_LIST;
          end else if (cmd_i.op == OP_BAD) begin
            status_d = ST_RANGE;
            state_d  = BS_RESP;
          end else if (cmd_i.zero_len) begin
            status_d = ST_OK;
            state_d  = BS_RESP;
          end else begin
            state_d = BS_SCAN;
          end
        end
      end

      // Walk the table up to the first extent that starts above the address.
      BS_SCAN: begin
        if (rd_ok_q && (rd_start_q > s_q)) begin
          p_d         = CW'(rd_idx_q);
          nxt_start_d = rd_start_q;
          nxt_len_d   = rd_len_q;
          state_d     = BS_DECIDE;
        end else begin
          if (rd_ok_q) begin
            prev_vld_d   = 1'b1;
            prev_idx_d   = rd_idx_q;
            prev_start_d = rd_start_q;
            prev_end_d   = rd_end;
          end
          if (rem_q != '0) begin
            rd_ok_d = 1'b1;
            sh_d    = sh_q + 1'b1;
            rem_d   = rem_q - 1'b1;
          end else if (!rd_ok_q) begin
            state_d = BS_DECIDE;
          end
        end
      end

      // Choose the edit from the neighbors found by the scan.
      BS_DECIDE: begin
        status_d  = ST_OK;
        wa_en_d   = 1'b0;
        wb_en_d   = 1'b0;
        sh_kind_d = SH_NONE;
        rem_d     = '0;
        state_d   = BS_WRA;
        if (op_q == OP_ALLOC) begin
          wa_addr_d = prev_idx_q;
          if (!in_ext || (e_q > prev_end_q)) begin
            status_d = ST_RANGE;
          end else if ((s_q == prev_start_q) && (e_q == prev_end_q)) begin
            sh_kind_d = SH_CLOSE;
            sh_d      = AW'(CW'(prev_idx_q) + CW'(1));
            rem_d     = count_q - CW'(1) - CW'(prev_idx_q);
          end else if (s_q == prev_start_q) begin
            wa_en_d    = 1'b1;
            wa_start_d = e_q[A-1:0];
            wa_len_d   = A'(prev_end_q - e_q);
          end else if (e_q == prev_end_q) begin
            wa_en_d    = 1'b1;
            wa_start_d = prev_start_q;
            wa_len_d   = s_q - prev_start_q;
          end else if (full_tab) begin
            status_d = ST_FULL;
          end else begin
            wa_en_d    = 1'b1;
            wa_start_d = prev_start_q;
            wa_len_d   = s_q - prev_start_q;
            sh_kind_d  = SH_OPEN;
            sh_d       = AW'(count_q - CW'(1));
            rem_d      = count_q - CW'(prev_idx_q) - CW'(1);
            wb_en_d    = 1'b1;
            wb_addr_d  = prev_idx_q + 1'b1;
            wb_start_d = e_q[A-1:0];
            wb_len_d   = A'(prev_end_q - e_q);
          end
        end else begin
          if ((e_q > upper) || (e_q > {1'b0, space_q})) begin
            status_d = ST_RANGE;
          end else if (prev_vld_q && (prev_end_q > s_x)) begin
            status_d = ST_RANGE;
          end else if (join_prev && join_next) begin
            wa_en_d    = 1'b1;
            wa_addr_d  = prev_idx_q;
            wa_start_d = prev_start_q;
            wa_len_d   = merged[A-1:0];
            sh_kind_d  = SH_CLOSE;
            sh_d       = AW'(p_q + CW'(1));
            rem_d      = count_q - CW'(1) - p_q;
          end else if (join_prev) begin
            wa_en_d    = 1'b1;
            wa_addr_d  = prev_idx_q;
            wa_start_d = prev_start_q;
            wa_len_d   = A'(plen + {1'b0, len_q});
          end else if (join_next) begin
            wa_en_d    = 1'b1;
            wa_addr_d  = p_q[AW-1:0];
            wa_start_d = s_q;
            wa_len_d   = nxt_len_q + len_q;
          end else if (full_tab) begin
            status_d = ST_FULL;
          end else begin
            sh_kind_d  = SH_OPEN;
            sh_d       = AW'(count_q - CW'(1));
            rem_d      = count_q - p_q;
            wb_en_d    = 1'b1;
            wb_addr_d  = p_q[AW-1:0];
            wb_start_d = s_q;
            wb_len_d   = len_q;
          end
        end
      end

      // First single write of the edit.
      BS_WRA: begin
        we      = wa_en_q;
        waddr   = wa_addr_q;
        wstart  = wa_start_q;
        wlen    = wa_len_q;
        state_d = BS_SHIFT;
      end

      // Move entries one place up or down, one entry a cycle.
      BS_SHIFT: begin
        if (rd_ok_q) begin
          we     = 1'b1;
          waddr  = (sh_kind_q == SH_OPEN) ? rd_idx_q + 1'b1 : rd_idx_q - 1'b1;
          wstart = rd_start_q;
          wlen   = rd_len_q;
        end
        if (rem_q != '0) begin
          rd_ok_d = 1'b1;
          sh_d    = (sh_kind_q == SH_OPEN) ? sh_q - 1'b1 : sh_q + 1'b1;
          rem_d   = rem_q - 1'b1;
        end else if (!rd_ok_q) begin
          case (sh_kind_q)
            SH_OPEN:  count_d = count_q + 1'b1;
            SH_CLOSE: count_d = count_q - 1'b1;
            default:  count_d = count_q;
          endcase
          state_d = BS_WRB;
        end
      end

      // Second single write of the edit.
      BS_WRB: begin
        we      = wb_en_q;
        waddr   = wb_addr_q;
        wstart  = wb_start_q;
        wlen    = wb_len_q;
        state_d = BS_RESP;
      end

      // Report the status of an allocate, free or bad request.
      BS_RESP: begin
        if (room) begin
          rsp_push_o = 1'b1;
          rsp_o      = '{status: status_q, extent_start: '0, extent_length: '0, last: 1'b1};
          state_d    = BS_IDLE;
        end
      end

      // Stream every extent into the result queue, or one empty last result when the table is empty.
      BS_LIST: begin
        if (count_q == '0) begin
          if (room) begin
            rsp_push_o = 1'b1;
            rsp_o      = '{status: ST_OK, extent_start: '0, extent_length: '0, last: 1'b1};
            state_d    = BS_IDLE;
          end
        end else begin
          if (rd_ok_q) begin
            rsp_push_o          = 1'b1;
            rsp_o.status        = ST_OK;
            rsp_o.extent_start  = out_s_ext[FIELD_W-1:0];
            rsp_o.extent_length = out_len_ext[FIELD_W-1:0];
            rsp_o.last          = ((CW'(rd_idx_q) + CW'(1)) == count_q);
          end
          if ((rem_q != '0) && room_list) begin
            rd_ok_d = 1'b1;
            sh_d    = sh_q + 1'b1;
            rem_d   = rem_q - 1'b1;
          end else if ((rem_q == '0) && !rd_ok_q) begin
            state_d = BS_IDLE;
          end
        end
      end

      default: begin
        state_d = BS_INIT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_INIT;
      space_q  <= SPACE_RST_EXT[A-1:0];
      count_q  <= '0;
      rd_ok_q  <= 1'b0;
      rem_q    <= '0;
      sh_q     <= '0;
    end else begin
      state_q  <= state_d;
      space_q  <= space_d;
      count_q  <= count_d;
      rd_ok_q  <= rd_ok_d;
      rem_q    <= rem_d;
      sh_q     <= sh_d;
    end
  end

  // Request and edit payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    s_q          <= s_d;
    len_q        <= len_d;
    e_q          <= e_d;
    prev_vld_q   <= prev_vld_d;
    prev_idx_q   <= prev_idx_d;
    prev_start_q <= prev_start_d;
    prev_end_q   <= prev_end_d;
    nxt_start_q  <= nxt_start_d;
    nxt_len_q    <= nxt_len_d;
    p_q          <= p_d;
    status_q     <= status_d;
    wa_en_q      <= wa_en_d;
    wa_addr_q    <= wa_addr_d;
    wa_start_q   <= wa_start_d;
    wa_len_q     <= wa_len_d;
    wb_en_q      <= wb_en_d;
    wb_addr_q    <= wb_addr_d;
    wb_start_q   <= wb_start_d;
    wb_len_q     <= wb_len_d;
    sh_kind_q    <= sh_kind_d;
    rd_idx_q     <= raddr;
  end

  // Extent table storage.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
    end
    rd_start_q <= mem_start[raddr];
    rd_len_q   <= mem_len[raddr];
  end

  `FET_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_EXTENTS))
  `FET_ASSERT(a_push_room, clk_i, rst_ni, !rsp_push_o || room)
  `FET_ASSERT_NEXT(a_cfg_reload, clk_i, rst_ni, cfg_wr_i && idle_o, state_q == BS_INIT)

endmodule

FILE: hw/rtl/free_extent_table_allocator_core.sv
// Top level of the free extent table allocator.
// Depends on fet_pkg, fet_front, fet_back and fet_rsp_fifo.
//
//   channel   handshake                 payload
//   request   push / full               req_i  (req_type, start_addr, range_length)
//   result    empty / pop               rsp_o  (status, extent_start, extent_length, last)
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (space_size)
//
// The back end pops a queued request when it is idle. An allocate or free scans the table,
// decides, writes, shifts one entry per cycle through the one table write port, writes again
// and reports. A list streams every extent; a zero-length or unknown request is reported
// without a scan. After reset and after each size write the BS_INIT state reloads the table.
// Requests queue two deep in front and results four deep behind; a full result queue stalls
// only the back end.
module free_extent_table_allocator_core
  import fet_pkg::*;
#(
  parameter int MAX_EXTENTS = 32,
  parameter int ADDR_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  req_t               req_i,
  output logic               empty,
  input  logic               pop,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FIELD_W-1:0] cfg_data_i
);

  logic                 cmd_valid, cmd_pop, back_idle, rsp_push;
  cmd_t                 cmd;
  rsp_t                 rsp_back;
  logic [RSP_CNT_W-1:0] rsp_used;

  // Size writes wait for an idle table with no request pending.
  assign cfg_ready_o = back_idle && !cmd_valid;

  fet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  fet_back #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .idle_o      (back_idle),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_back),
    .rsp_used_i  (rsp_used)
  );

  fet_rsp_fifo u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_back),
    .used_o  (rsp_used),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (rsp_o)
  );

endmodule

FILE: bench/tb_free_extent_table_allocator_core.sv
// Self-checking testbench for the free extent table allocator core.
// Depends on fet_pkg and free_extent_table_allocator_core, and through it on the rest of the RTL.
`timescale 1ns / 1ps

module tb_free_extent_table_allocator_core;
  import fet_pkg::*;

  localparam int N_EXT = 32;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  req_t req_i;
  logic empty;
  logic pop;
  rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [FIELD_W-1:0] cfg_data_i;

  free_extent_table_allocator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .req_i(req_i),
    .empty(empty), .pop(pop), .rsp_o(rsp_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Predicted free table, kept in the testbench's own terms.
  logic [16:0] tbl_start [N_EXT];
  logic [16:0] tbl_len [N_EXT];
  int          tbl_count;
  logic [16:0] space_words;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   err_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_pop;
  bit   drain_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reload the table with one extent covering the space.
  function automatic void table_reload(logic [15:0] size);
    space_words = {1'b0, size};
    for (int k = 0; k < N_EXT; k++) begin
      tbl_start[k] = '0;
      tbl_len[k] = '0;
    end
    tbl_len[0] = {1'b0, size};
    tbl_count = (size == 0) ? 0 : 1;
  endfunction

  function automatic void slot_open(int pos);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k] = tbl_len[k-1];
    end
    tbl_count++;
  endfunction

  function automatic void slot_close(int pos);
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k] = tbl_len[k+1];
    end
    tbl_count--;
  endfunction

  function automatic status_e carve_range(logic [16:0] s, logic [16:0] len);
    logic [16:0] e;
    logic [16:0] ms;
    logic [16:0] me;
    e = s + len;
    if (len == 0) return ST_OK;
    for (int i = 0; i < tbl_count; i++) begin
      ms = tbl_start[i];
      me = ms + tbl_len[i];
      if (s >= ms && s < me) begin
        if (e > me) return ST_RANGE;
        if (s == ms && e == me) slot_close(i);
        else if (s == ms) begin
          tbl_start[i] = e;
          tbl_len[i] = me - e;
        end else if (e == me) tbl_len[i] = s - ms;
        else begin
          if (tbl_count >= N_EXT) return ST_FULL;
          slot_open(i + 1);
          tbl_len[i] = s - ms;
          tbl_start[i+1] = e;
          tbl_len[i+1] = me - e;
        end
        return ST_OK;
      end
    end
    return ST_RANGE;
  endfunction

  function automatic status_e return_range(logic [16:0] s, logic [16:0] len);
    int p;
    logic [16:0] e;
    logic [16:0] upper;
    logic [16:0] pe;
    bit jp;
    bit jn;
    p = 0;
    e = s + len;
    jp = 0;
    if (len == 0) return ST_OK;
    while (p < tbl_count && tbl_start[p] <= s) p++;
    upper = (p < tbl_count) ? tbl_start[p] : space_words;
    if (e > upper || e > space_words) return ST_RANGE;
    if (p > 0) begin
      pe = tbl_start[p-1] + tbl_len[p-1];
      if (pe > s) return ST_RANGE;
      jp = (pe == s);
    end
    jn = (p < tbl_count) && (tbl_start[p] == e);
    if (jp && jn) begin
      tbl_len[p-1] += len + tbl_len[p];
      slot_close(p);
    end else if (jp) tbl_len[p-1] += len;
    else if (jn) begin
      tbl_start[p] = s;
      tbl_len[p] += len;
    end else begin
      if (tbl_count >= N_EXT) return ST_FULL;
      slot_open(p);
      tbl_start[p] = s;
      tbl_len[p] = len;
    end
    return ST_OK;
  endfunction

  // Work out the results of one accepted request.
  function automatic void predict_request(req_t r);
    rsp_t x;
    x = '0;
    x.last = 1'b1;
    case (op_e'(r.req_type))
      OP_LIST: begin
        if (tbl_count == 0) expected_rsps.push_back(x);
        for (int i = 0; i < tbl_count; i++) begin
          x.status = ST_OK;
          x.extent_start = tbl_start[i][15:0];
          x.extent_length = tbl_len[i][15:0];
          x.last = (i + 1 == tbl_count);
          expected_rsps.push_back(x);
        end
      end
      OP_ALLOC: begin
        x.status = carve_range({1'b0, r.start_addr}, {1'b0, r.range_length});
        expected_rsps.push_back(x);
      end
      OP_FREE: begin
        x.status = return_range({1'b0, r.start_addr}, {1'b0, r.range_length});
        expected_rsps.push_back(x);
      end
      default: begin
        x.status = ST_RANGE;
        expected_rsps.push_back(x);
      end
    endcase
  endfunction

  // Driver: offers queued items, with random idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      req_i <= '0;
    end else begin
      if (push && !full) predict_request(req_i);
      if ((!push || !full) && pending_reqs.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        req_i <= pending_reqs.pop_front();
      end else if (!push || !full) begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pops results and checks them against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: %p", rsp_o);
          err_count++;
        end else begin
          rsp_t x;
          x = expected_rsps.pop_front();
          if (rsp_o.status !== x.status) begin
            $error("status expected %0d actual %0d", x.status, rsp_o.status);
            err_count++;
          end
          if (rsp_o.extent_start !== x.extent_start) begin
            $error("extent_start expected %0d actual %0d", x.extent_start,
                   rsp_o.extent_start);
            err_count++;
          end
          if (rsp_o.extent_length !== x.extent_length) begin
            $error("extent_length expected %0d actual %0d", x.extent_length,
                   rsp_o.extent_length);
            err_count++;
          end
          if (rsp_o.last !== x.last) begin
            $error("last expected %0d actual %0d", x.last, rsp_o.last);
            err_count++;
          end
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_req(op_e op, int s, int len);
    req_t r;
    r.req_type = op;
    r.start_addr = s[15:0];
    r.range_length = len[15:0];
    pending_reqs.push_back(r);
  endtask

  // Wait until every item is sent and every result checked, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_size(logic [15:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    table_reload(size);
    @(posedge clk_i);
  endtask

  // Well-formed traffic inside the given space, plus some noise.
  task automatic add_random(int n, logic [15:0] size);
    int s;
    int len;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      s = $urandom_range(size);
      len = (pick < 80) ? $urandom_range(64) : $urandom_range(65535);
      if (pick < 8) add_req(OP_LIST, $urandom, $urandom);
      else if (pick < 10) add_req(OP_BAD, $urandom, $urandom);
      else if (pick < 55) add_req(OP_ALLOC, s, len);
      else if (pick < 95) add_req(OP_FREE, s, len);
      else add_req(op_e'($urandom_range(3)), $urandom, $urandom);
    end
  endtask

  initial begin
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_pop = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    table_reload(16'hFFFF);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // Directed: extremes, every request kind, and the special cases.
    add_req(OP_LIST, 0, 0);
    add_req(OP_ALLOC, 100, 0);
    add_req(OP_FREE, 100, 0);
    add_req(OP_ALLOC, 65534, 2);
    add_req(OP_ALLOC, 0, 10);
    add_req(OP_ALLOC, 65525, 10);
    add_req(OP_ALLOC, 1000, 100);
    add_req(OP_FREE, 1050, 10);
    add_req(OP_FREE, 0, 5);
    add_req(OP_FREE, 65535, 1);
    add_req(OP_FREE, 1000, 50);
    add_req(OP_FREE, 1060, 40);
    add_req(OP_BAD, 16'hFFFF, 16'hFFFF);
    add_req(OP_LIST, 16'hFFFF, 16'hFFFF);
    add_req(OP_ALLOC, 0, 65535);
    add_req(OP_LIST, 0, 0);
    add_req(OP_FREE, 0, 65535);
    drain();

    // Fill the table with holes, overflow it with splits, then free an already free address.
    write_size(16'd200);
    for (int i = 0; i < 33; i++) add_req(OP_ALLOC, 2 + 3 * i, 1);
    add_req(OP_FREE, 199, 1);
    add_req(OP_LIST, 0, 0);
    drain();

    // Empty table.
    write_size(16'd0);
    add_req(OP_LIST, 0, 0);
    add_req(OP_FREE, 0, 1);
    add_req(OP_ALLOC, 0, 1);
    drain();

    // Random phases across the idling patterns and several sizes.
    write_size(16'd1);
    send_idle_pct = 0; recv_stall_pct = 0;
    add_random(60, 16'd300);
    drain();
    write_size(16'd300);
    send_idle_pct = 50; recv_stall_pct = 0;
    add_random(90, 16'd300);
    drain();
    write_size(16'd1000);
    send_idle_pct = 0; recv_stall_pct = 50;
    add_random(90, 16'd1000);
    drain();
    write_size(16'hFFFF);
    send_idle_pct = 29; recv_stall_pct = 29;
    add_random(90, 16'hFFFF);
    drain();

    // Long receiver hold-off, counted in its own process, while the sender keeps going.
    write_size(16'd500);
    send_idle_pct = 0; recv_stall_pct = 0;
    add_random(60, 16'd500);
    fork
      begin
        hold_pop <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_pop <= 1'b0;
      end
    join_none
    drain();

    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
